// ----- rtl/core/rvo_pkg.sv -----
package rvo_pkg;

	// register indexes of the configuration port
	localparam logic [1:0] RVO_REG_SMA = 2'd0;
	localparam logic [1:0] RVO_REG_WMA = 2'd1;
	localparam logic [1:0] RVO_REG_MAX = 2'd2;

	// default ring depths
	localparam int RVO_MAX_SMA_DEF = 64;
	localparam int RVO_MAX_WMA_DEF = 64;

	// fixed field widths
	localparam int PRICE_W = 32;
	localparam int LEN_W   = 7;
	localparam int MAXV_W  = 18;
	localparam int RATIO_W = 18;
	localparam int OSC_W   = 17;
	localparam int RSUM_W  = 25;
	localparam int ASUM_W  = 25;
	localparam int WSUM_W  = 32;
	localparam int BARS_W  = 8;
	localparam int TRI_W   = 13;

	// shared divider: dividend bits, divisor bits, step counts per operation
	localparam int DVD_W = 48;
	localparam int DVS_W = 32;
	localparam int CNT_W = 6;
	localparam logic [CNT_W-1:0] STEPS_RATIO = 6'd48;
	localparam logic [CNT_W-1:0] STEPS_AVG   = 6'd24;
	localparam logic [CNT_W-1:0] STEPS_FINAL = 6'd46;

	// controller to datapath commands
	typedef struct packed {
		logic load_bar;
		logic ratio_start;
		logic ratio_upd;
		logic avg_start;
		logic avg_upd;
		logic den_t;
		logic den_mul;
		logic fin_start;
		logic out_load;
	} rvo_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_done;
		logic ratio_warm;
		logic avg_warm;
	} rvo_sts_t;

endpackage

// ----- rtl/core/rvo_if.sv -----
interface rvo_bar_if;
	import rvo_pkg::*;
	logic               valid;
	logic               ready;
	logic [PRICE_W-1:0] opening;
	logic [PRICE_W-1:0] highest;
	logic [PRICE_W-1:0] lowest;
	logic [PRICE_W-1:0] closing;
	modport source (output valid, opening, highest, lowest, closing,
		input ready);
	modport sink (input valid, opening, highest, lowest, closing,
		output ready);
endinterface

interface rvo_osc_if;
	import rvo_pkg::*;
	logic             valid;
	logic             ready;
	logic [OSC_W-1:0] oscillator;
	modport source (output valid, oscillator, input ready);
	modport sink (input valid, oscillator, output ready);
endinterface

// ----- rtl/core/rvo_div.sv -----
module rvo_div
	import rvo_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	input  logic [CNT_W-1:0] steps,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic [DVS_W-1:0] rem_q;
	logic [DVD_W-1:0] sh_q;
	logic [DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             qbit;
	logic [DVS_W:0]   diff;

	// one restoring step per cycle
	always_comb begin
		trial = {rem_q, sh_q[DVD_W-1]};
		diff  = trial - {1'b0, dvs_q};
		qbit  = (trial >= {1'b0, dvs_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// payload: remainder, shifting dividend/quotient, held divisor
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			sh_q  <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
			sh_q  <= {sh_q[DVD_W-2:0], qbit};
		end
	end

	assign done     = done_q;
	assign quotient = sh_q;

endmodule

// ----- rtl/core/rvo_ctrl.sv -----
module rvo_ctrl
	import rvo_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	output logic     out_valid,
	input  logic     out_ready,
	input  rvo_sts_t sts,
	output rvo_cmd_t cmd
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_RSTART = 4'd1;
	localparam logic [3:0] ST_RWAIT  = 4'd2;
	localparam logic [3:0] ST_RUPD   = 4'd3;
	localparam logic [3:0] ST_ASTART = 4'd4;
	localparam logic [3:0] ST_AWAIT  = 4'd5;
	localparam logic [3:0] ST_AUPD   = 4'd6;
	localparam logic [3:0] ST_DEN1   = 4'd7;
	localparam logic [3:0] ST_DEN2   = 4'd8;
	localparam logic [3:0] ST_FSTART = 4'd9;
	localparam logic [3:0] ST_FWAIT  = 4'd10;
	localparam logic [3:0] ST_OUT    = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       valid_q;
	logic       slot_free;

	assign slot_free = !valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = valid_q;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_bar = 1'b1;
					state_d      = ST_RSTART;
				end
			end
			ST_RSTART: begin
				cmd.ratio_start = 1'b1;
				state_d         = ST_RWAIT;
			end
			ST_RWAIT: begin
				if (sts.div_done) state_d = ST_RUPD;
			end
			ST_RUPD: begin
				cmd.ratio_upd = 1'b1;
				state_d       = sts.ratio_warm ? ST_IDLE : ST_ASTART;
			end
			ST_ASTART: begin
				cmd.avg_start = 1'b1;
				state_d       = ST_AWAIT;
			end
			ST_AWAIT: begin
				if (sts.div_done) state_d = ST_AUPD;
			end
			ST_AUPD: begin
				cmd.avg_upd = 1'b1;
				state_d     = sts.avg_warm ? ST_IDLE : ST_DEN1;
			end
			ST_DEN1: begin
				cmd.den_t = 1'b1;
				state_d   = ST_DEN2;
			end
			ST_DEN2: begin
				cmd.den_mul = 1'b1;
				state_d     = ST_FSTART;
			end
			ST_FSTART: begin
				cmd.fin_start = 1'b1;
				state_d       = ST_FWAIT;
			end
			ST_FWAIT: begin
				if (sts.div_done) state_d = ST_OUT;
			end
			ST_OUT: begin
				// hold until the output register is free
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)   valid_q <= 1'b1;
			else if (out_ready) valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/rvo_dp.sv -----
module rvo_dp
	import rvo_pkg::*;
#(
	parameter int MAX_SMA = RVO_MAX_SMA_DEF,
	parameter int MAX_WMA = RVO_MAX_WMA_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rvo_cmd_t           cmd,
	output rvo_sts_t           sts,
	input  logic               clear,
	input  logic [LEN_W-1:0]   sma_raw,
	input  logic [LEN_W-1:0]   wma_raw,
	input  logic [MAXV_W-1:0]  maxv_raw,
	input  logic [PRICE_W-1:0] opening,
	input  logic [PRICE_W-1:0] highest,
	input  logic [PRICE_W-1:0] lowest,
	input  logic [PRICE_W-1:0] closing,
	output logic [OSC_W-1:0]   oscillator
);

	localparam int SAW = (MAX_SMA > 1) ? $clog2(MAX_SMA) : 1;
	localparam int WAW = (MAX_WMA > 1) ? $clog2(MAX_WMA) : 1;
	localparam int SXW = ((SAW > LEN_W) ? SAW : LEN_W) + 1;
	localparam int WXW = ((WAW > LEN_W) ? WAW : LEN_W) + 1;

	// effective window lengths and full scale
	logic [LEN_W-1:0]  ls;
	logic [LEN_W-1:0]  lw;
	logic [MAXV_W-1:0] mv;

	always_comb begin
		if (sma_raw == '0)                 ls = LEN_W'(1);
		else if (32'(sma_raw) > MAX_SMA)   ls = LEN_W'(MAX_SMA);
		else                               ls = sma_raw;
		if (wma_raw == '0)                 lw = LEN_W'(1);
		else if (32'(wma_raw) > MAX_WMA)   lw = LEN_W'(MAX_WMA);
		else                               lw = wma_raw;
		mv = (maxv_raw == '0) ? MAXV_W'(1) : maxv_raw;
	end

	// state
	logic signed [RATIO_W-1:0] rring [MAX_SMA];
	logic signed [RATIO_W-1:0] aring [MAX_WMA];
	logic signed [RATIO_W-1:0] r_old_q;
	logic signed [RATIO_W-1:0] a_old_q;
	logic signed [RSUM_W-1:0]  rsum_q;
	logic signed [ASUM_W-1:0]  asum_q;
	logic signed [WSUM_W-1:0]  wsum_q;
	logic [BARS_W-1:0]         bars_q;
	logic [SAW-1:0]            rptr_q;
	logic [WAW-1:0]            aptr_q;
	logic [PRICE_W-1:0]        open_q, high_q, low_q, close_q;
	logic                      neg_q;
	logic [TRI_W-1:0]          tri_q;
	logic [DVS_W-1:0]          den_q;
	logic [OSC_W-1:0]          osc_q;

	// divider operands
	logic             div_start;
	logic [DVD_W-1:0] dvd;
	logic [DVS_W-1:0] dvs;
	logic [CNT_W-1:0] steps;
	logic             dneg;
	logic [DVD_W-1:0] quot;
	logic             div_done;

	logic signed [PRICE_W:0] pdiff;
	logic [PRICE_W-1:0]      pmag;
	logic [PRICE_W-1:0]      prange;
	logic [RSUM_W-1:0]       rsum_mag;
	logic [WSUM_W-1:0]       wsum_mag;

	always_comb begin
		pdiff    = $signed({1'b0, close_q}) - $signed({1'b0, open_q});
		pmag     = pdiff[PRICE_W] ? PRICE_W'(-pdiff) : pdiff[PRICE_W-1:0];
		prange   = (high_q > low_q) ? (high_q - low_q) : PRICE_W'(1);
		rsum_mag = rsum_q[RSUM_W-1] ? RSUM_W'(-rsum_q) : RSUM_W'(rsum_q);
		wsum_mag = wsum_q[WSUM_W-1] ? WSUM_W'(-wsum_q) : WSUM_W'(wsum_q);
		div_start = cmd.ratio_start | cmd.avg_start | cmd.fin_start;
		if (cmd.ratio_start) begin
			dvd   = {pmag, 16'd0};
			dvs   = prange;
			steps = STEPS_RATIO;
			dneg  = pdiff[PRICE_W];
		end else if (cmd.avg_start) begin
			dvd   = {rsum_mag[23:0], 24'd0};
			dvs   = DVS_W'(ls);
			steps = STEPS_AVG;
			dneg  = rsum_q[RSUM_W-1];
		end else begin
			dvd   = {wsum_mag[29:0], 18'd0};
			dvs   = den_q;
			steps = STEPS_FINAL;
			dneg  = wsum_q[WSUM_W-1];
		end
	end

	rvo_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd),
		.divisor  (dvs),
		.steps    (steps),
		.done     (div_done),
		.quotient (quot)
	);

	// old entry addresses: pointer minus window, wrapped
	logic signed [SXW-1:0] rdiff;
	logic signed [WXW-1:0] adiff;
	logic [SAW-1:0]        raddr;
	logic [WAW-1:0]        aaddr;

	always_comb begin
		rdiff = $signed(SXW'(rptr_q)) - $signed(SXW'(ls));
		adiff = $signed(WXW'(aptr_q)) - $signed(WXW'(lw));
		raddr = rdiff[SXW-1] ? SAW'(rdiff + SXW'(MAX_SMA)) : SAW'(rdiff);
		aaddr = adiff[WXW-1] ? WAW'(adiff + WXW'(MAX_WMA)) : WAW'(adiff);
	end

	// saturated ratio and signed average from the quotient
	logic signed [RATIO_W-1:0] r_new;
	logic signed [RATIO_W-1:0] a_new;
	logic [BARS_W-1:0]         n1;
	logic [BARS_W-1:0]         m;
	logic                      r_full;
	logic                      a_full;
	logic [BARS_W-1:0]         wmul;
	logic signed [26:0]        wprod;

	always_comb begin
		if (neg_q) r_new = (quot > DVD_W'(131072)) ? RATIO_W'(-131072)
			: RATIO_W'(-$signed({1'b0, quot[RATIO_W-1:0]}));
		else r_new = (quot > DVD_W'(131071)) ? RATIO_W'(131071)
			: $signed(quot[RATIO_W-1:0]);
		a_new  = neg_q ? RATIO_W'(-$signed({1'b0, quot[RATIO_W-1:0]}))
			: $signed(quot[RATIO_W-1:0]);
		n1     = (bars_q == '1) ? bars_q : bars_q + 1'b1;
		r_full = (bars_q >= BARS_W'(ls));
		m      = bars_q - BARS_W'(ls) + 1'b1;
		a_full = (m > BARS_W'(lw));
		wmul   = a_full ? BARS_W'(lw) : m;
		wprod  = $signed({1'b0, wmul}) * a_new;
		sts.div_done   = div_done;
		sts.ratio_warm = (n1 < BARS_W'(ls));
		sts.avg_warm   = (m < BARS_W'(lw));
	end

	// control-like state: sums, counters, pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsum_q <= '0;
			asum_q <= '0;
			wsum_q <= '0;
			bars_q <= '0;
			rptr_q <= '0;
			aptr_q <= '0;
		end else if (clear) begin
			rsum_q <= '0;
			asum_q <= '0;
			wsum_q <= '0;
			bars_q <= '0;
			rptr_q <= '0;
			aptr_q <= '0;
		end else begin
			if (cmd.ratio_upd) begin
				rsum_q <= rsum_q + RSUM_W'(r_new)
					- (r_full ? RSUM_W'(r_old_q) : RSUM_W'(0));
				rptr_q <= (rptr_q == SAW'(MAX_SMA - 1)) ? '0 : rptr_q + 1'b1;
				bars_q <= n1;
			end
			if (cmd.avg_upd) begin
				if (a_full) begin
					wsum_q <= wsum_q - WSUM_W'(asum_q) + WSUM_W'(wprod);
					asum_q <= asum_q - ASUM_W'(a_old_q) + ASUM_W'(a_new);
				end else begin
					wsum_q <= wsum_q + WSUM_W'(wprod);
					asum_q <= asum_q + ASUM_W'(a_new);
				end
				aptr_q <= (aptr_q == WAW'(MAX_WMA - 1)) ? '0 : aptr_q + 1'b1;
			end
		end
	end

	// ring memories
	always_ff @(posedge clk) begin
		if (cmd.ratio_upd) rring[rptr_q] <= r_new;
		if (cmd.ratio_start) r_old_q <= rring[raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.avg_upd) aring[aptr_q] <= a_new;
		if (cmd.avg_start) a_old_q <= aring[aaddr];
	end

	// final clamp and mapping to [0, 1]
	logic [16:0] qc;
	logic [17:0] osc_sum;

	always_comb begin
		qc      = (quot > DVD_W'(65536)) ? 17'd65536 : quot[16:0];
		osc_sum = neg_q ? (18'd65536 - {1'b0, qc}) : (18'd65536 + {1'b0, qc});
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_bar) begin
			open_q  <= opening;
			high_q  <= highest;
			low_q   <= lowest;
			close_q <= closing;
		end
		if (div_start) neg_q <= dneg;
		if (cmd.den_t) tri_q <= TRI_W'(({8'd0, lw} * {7'd0, lw + 8'd1}) >> 1);
		if (cmd.den_mul) den_q <= DVS_W'(tri_q) * DVS_W'(mv);
		if (cmd.out_load) osc_q <= osc_sum[17:1];
	end

	assign oscillator = osc_q;

endmodule

// ----- rtl/core/relative_vigor_oscillator.sv -----
// Relative vigor oscillator.
// Input channel "bar" takes one price bar (open, high, low, close) per request;
// output channel "osc" returns one oscillator value in Q1.16 per request once
// sma_length + wma_length - 1 bars have been seen since reset or since a
// window length was written. Earlier bars give no result.
// Each bar runs through one shared restoring divider, one quotient bit per
// cycle: 48 steps for the vigor ratio, 24 for the simple average and 46 for
// the normalizing division. While the simple or weighted average still fills,
// a bar ends after the ratio or average update; a new bar is taken only once
// the last one is through. The result sits in an output register, so a
// stalled receiver does not block the next bar; only when a second result is
// ready while the first is still held does the block wait.
// Configuration (cfg_we, cfg_index, cfg_wdata) must be written while idle;
// the block itself does not enforce it. Writing either window length
// restarts warm-up. Reset (arst_n low) loads the default registers and
// clears all sums, counters and pointers.
module relative_vigor_oscillator
	import rvo_pkg::*;
#(
	parameter int MAX_SMA = RVO_MAX_SMA_DEF,
	parameter int MAX_WMA = RVO_MAX_WMA_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	rvo_bar_if.sink           bar,
	rvo_osc_if.source         osc,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [MAXV_W-1:0] cfg_wdata
);

	logic [LEN_W-1:0]  sma_q;
	logic [LEN_W-1:0]  wma_q;
	logic [MAXV_W-1:0] maxv_q;
	logic              clear;
	rvo_cmd_t          cmd;
	rvo_sts_t          sts;

	// configuration registers
	assign clear = cfg_we && (cfg_index == RVO_REG_SMA || cfg_index == RVO_REG_WMA);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sma_q  <= LEN_W'(10);
			wma_q  <= LEN_W'(4);
			maxv_q <= MAXV_W'(65536);
		end else if (cfg_we) begin
			case (cfg_index)
				RVO_REG_SMA: sma_q  <= cfg_wdata[LEN_W-1:0];
				RVO_REG_WMA: wma_q  <= cfg_wdata[LEN_W-1:0];
				RVO_REG_MAX: maxv_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	rvo_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (bar.valid),
		.in_ready  (bar.ready),
		.out_valid (osc.valid),
		.out_ready (osc.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	rvo_dp #(
		.MAX_SMA (MAX_SMA),
		.MAX_WMA (MAX_WMA)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.clear      (clear),
		.sma_raw    (sma_q),
		.wma_raw    (wma_q),
		.maxv_raw   (maxv_q),
		.opening    (bar.opening),
		.highest    (bar.highest),
		.lowest     (bar.lowest),
		.closing    (bar.closing),
		.oscillator (osc.oscillator)
	);

`ifndef SYNTHESIS
	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!osc.valid || osc.ready))
		else $error("output register overwritten");

	// an accepted bar keeps the input closed for the next cycle
	a_one_bar: assert property (@(posedge clk) disable iff (!arst_n)
		(bar.valid && bar.ready) |=> !bar.ready)
		else $error("second bar taken while busy");

	// divider is only started from a state that does not take bars
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.ratio_start || cmd.avg_start || cmd.fin_start) |-> !bar.ready)
		else $error("divider started while idle");
`endif

endmodule
